FILE: design/tllc_pkg.sv
// shared types and constants for the three-light lane controller
package tllc_pkg;

   // lane state codes, also the value shown on the result lane_state field
   typedef enum logic [2:0] {
      LANE_OFF     = 3'd0,
      LANE_TO_STOP = 3'd1,
      LANE_STOP    = 3'd2,
      LANE_TO_GO   = 3'd3,
      LANE_GO      = 3'd4,
      LANE_OOO     = 3'd5
   } lane_mode_type;

   // request codes carried with a state request
   typedef enum logic [1:0] {
      REQ_OFF  = 2'd0,
      REQ_STOP = 2'd1,
      REQ_GO   = 2'd2,
      REQ_OOO  = 2'd3
   } request_type;

   // transaction kind
   localparam logic OP_TICK    = 1'b0;
   localparam logic OP_REQUEST = 1'b1;

   // configuration register indexes
   localparam logic [1:0] CSR_TRANSITION_TICKS = 2'd0;
   localparam logic [1:0] CSR_BLINK_TICKS      = 2'd1;
   localparam logic [1:0] CSR_LIGHTS_FITTED    = 2'd2;

   localparam int unsigned CSR_DATA_WIDTH  = 16;
   localparam int unsigned CSR_INDEX_WIDTH = 2;

   // light bits: bit0 red, bit1 yellow, bit2 green
   localparam logic [2:0] LIGHT_NONE   = 3'b000;
   localparam logic [2:0] LIGHT_RED    = 3'b001;
   localparam logic [2:0] LIGHT_YELLOW = 3'b010;
   localparam logic [2:0] LIGHT_GREEN  = 3'b100;
   localparam logic [2:0] LIGHT_ALL    = 3'b111;

   // register reset values
   localparam logic [CSR_DATA_WIDTH-1:0] RESET_TRANSITION_TICKS = 16'd2000;
   localparam logic [CSR_DATA_WIDTH-1:0] RESET_BLINK_TICKS      = 16'd1500;

endpackage

FILE: design/three_light_lane_controller_core.sv
// three-light lane controller: request/tick handling, timers and light drive
//
//   channel | direction | handshake                    | payload
//   --------+-----------+------------------------------+-------------------------------
//   req     | in        | req_valid / req_ready        | req_op, req_request
//   rsp     | out       | rsp_valid / rsp_ready        | rsp_red_on, rsp_yellow_on,
//           |           |                              | rsp_green_on, rsp_lane_state
//   csr     | in        | csr_write_en (no wait)       | csr_index, csr_write_data
//
// the lane state and both counters update at the accepting edge and the result
// register loads in the same edge.
// a new transaction is taken every cycle while the result register is empty or
// is being drained; a stalled result holds req_ready low.
// reset (synchronous) sets the lane off, clears timers and loads register defaults.
module three_light_lane_controller_core #(
   parameter int unsigned TIMER_WIDTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_op,
   input  logic [1:0]                            req_request,
   // result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_red_on,
   output logic                                  rsp_yellow_on,
   output logic                                  rsp_green_on,
   output logic [2:0]                            rsp_lane_state,
   // configuration port
   input  logic                                  csr_write_en,
   input  logic [tllc_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [tllc_pkg::CSR_DATA_WIDTH-1:0]   csr_write_data
);

   localparam logic [TIMER_WIDTH-1:0] TIMER_ZERO = '0;
   localparam logic [TIMER_WIDTH-1:0] TIMER_ONE  = {{(TIMER_WIDTH-1){1'b0}}, 1'b1};

   // configuration registers
   logic [tllc_pkg::CSR_DATA_WIDTH-1:0] transition_ticks_ff;
   logic [tllc_pkg::CSR_DATA_WIDTH-1:0] blink_ticks_ff;
   logic [2:0]                          lights_fitted_ff;

   // lane state
   tllc_pkg::lane_mode_type mode_ff, mode_in;
   logic [TIMER_WIDTH-1:0]  trans_count_ff, trans_count_in;
   logic [TIMER_WIDTH-1:0]  blink_count_ff, blink_count_in;
   logic [2:0]              light_bits_ff, light_bits_in;

   // result register
   logic       rsp_valid_ff;
   logic [2:0] rsp_lights_ff;
   logic [2:0] rsp_state_ff;

   logic                    accept;
   logic [TIMER_WIDTH-1:0]  trans_cut, blink_cut;
   logic [TIMER_WIDTH-1:0]  trans_load, blink_load;
   logic [TIMER_WIDTH-1:0]  trans_dec, blink_dec;
   logic                    tick_in_transition, tick_in_blink;
   tllc_pkg::request_type   req_code;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign req_code  = tllc_pkg::request_type'(req_request);

   // period loads: cut to the timer width, zero acts as one
   assign trans_cut  = TIMER_WIDTH'(transition_ticks_ff);
   assign blink_cut  = TIMER_WIDTH'(blink_ticks_ff);
   assign trans_load = (trans_cut == TIMER_ZERO) ? TIMER_ONE : trans_cut;
   assign blink_load = (blink_cut == TIMER_ZERO) ? TIMER_ONE : blink_cut;

   assign trans_dec = trans_count_ff - TIMER_ONE;
   assign blink_dec = blink_count_ff - TIMER_ONE;

   assign tick_in_transition = (mode_ff == tllc_pkg::LANE_TO_STOP ||
                                mode_ff == tllc_pkg::LANE_TO_GO) &&
                               (trans_count_ff != TIMER_ZERO);
   assign tick_in_blink      = (mode_ff == tllc_pkg::LANE_OOO) &&
                               (blink_count_ff != TIMER_ZERO);

   // next lane state
   always_comb begin
      mode_in = mode_ff;
      if (req_op == tllc_pkg::OP_REQUEST) begin
         case (req_code)
            tllc_pkg::REQ_OFF:  mode_in = tllc_pkg::LANE_OFF;
            tllc_pkg::REQ_STOP: mode_in = tllc_pkg::LANE_TO_STOP;
            tllc_pkg::REQ_GO:   mode_in = tllc_pkg::LANE_TO_GO;
            tllc_pkg::REQ_OOO:  mode_in = tllc_pkg::LANE_OOO;
            default:            mode_in = mode_ff;
         endcase
      end else if (tick_in_transition && trans_dec == TIMER_ZERO) begin
         mode_in = (mode_ff == tllc_pkg::LANE_TO_STOP) ? tllc_pkg::LANE_STOP
                                                       : tllc_pkg::LANE_GO;
      end
   end

   // timers and light bits
   always_comb begin
      trans_count_in = trans_count_ff;
      blink_count_in = blink_count_ff;
      light_bits_in  = light_bits_ff;
      if (req_op == tllc_pkg::OP_REQUEST) begin
         case (req_code)
            tllc_pkg::REQ_OFF: begin
               light_bits_in  = tllc_pkg::LIGHT_NONE;
               trans_count_in = TIMER_ZERO;
               blink_count_in = TIMER_ZERO;
            end
            tllc_pkg::REQ_STOP: begin
               light_bits_in  = tllc_pkg::LIGHT_YELLOW;
               trans_count_in = trans_load;
               blink_count_in = TIMER_ZERO;
            end
            tllc_pkg::REQ_GO: begin
               light_bits_in  = tllc_pkg::LIGHT_RED | tllc_pkg::LIGHT_YELLOW;
               trans_count_in = trans_load;
               blink_count_in = TIMER_ZERO;
            end
            tllc_pkg::REQ_OOO: begin
               light_bits_in  = tllc_pkg::LIGHT_NONE;
               trans_count_in = TIMER_ZERO;
               blink_count_in = blink_load;
            end
            default: begin
               light_bits_in = light_bits_ff;
            end
         endcase
      end else if (tick_in_transition) begin
         trans_count_in = trans_dec;
         if (trans_dec == TIMER_ZERO) begin
            light_bits_in = (mode_ff == tllc_pkg::LANE_TO_STOP) ? tllc_pkg::LIGHT_RED
                                                                : tllc_pkg::LIGHT_GREEN;
         end
      end else if (tick_in_blink) begin
         if (blink_dec == TIMER_ZERO) begin
            light_bits_in  = light_bits_ff ^ tllc_pkg::LIGHT_YELLOW;
            blink_count_in = blink_load;
         end else begin
            blink_count_in = blink_dec;
         end
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         transition_ticks_ff <= tllc_pkg::RESET_TRANSITION_TICKS;
         blink_ticks_ff      <= tllc_pkg::RESET_BLINK_TICKS;
         lights_fitted_ff    <= tllc_pkg::LIGHT_ALL;
      end else if (csr_write_en) begin
         case (csr_index)
            tllc_pkg::CSR_TRANSITION_TICKS: transition_ticks_ff <= csr_write_data;
            tllc_pkg::CSR_BLINK_TICKS:      blink_ticks_ff      <= csr_write_data;
            tllc_pkg::CSR_LIGHTS_FITTED:    lights_fitted_ff    <= csr_write_data[2:0];
            default:                        ;
         endcase
      end
   end

   // lane state update on each transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= tllc_pkg::LANE_OFF;
         trans_count_ff <= TIMER_ZERO;
         blink_count_ff <= TIMER_ZERO;
         light_bits_ff  <= tllc_pkg::LIGHT_NONE;
      end else if (accept) begin
         mode_ff        <= mode_in;
         trans_count_ff <= trans_count_in;
         blink_count_ff <= blink_count_in;
         light_bits_ff  <= light_bits_in;
      end
   end

   // result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result payload, masked by fitted lights
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_lights_ff <= light_bits_in & lights_fitted_ff;
         rsp_state_ff  <= 3'(mode_in);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_red_on     = rsp_lights_ff[0];
   assign rsp_yellow_on  = rsp_lights_ff[1];
   assign rsp_green_on   = rsp_lights_ff[2];
   assign rsp_lane_state = rsp_state_ff;

endmodule

FILE: design/tllc_checker.sv
// port-level checks for the three-light lane controller, bound to the core module
module tllc_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 req_op,
   input logic [1:0]                           req_request,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic                                 rsp_red_on,
   input logic                                 rsp_yellow_on,
   input logic                                 rsp_green_on,
   input logic [2:0]                           rsp_lane_state
);

   // a stalled result holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid &&
         $stable({rsp_red_on, rsp_yellow_on, rsp_green_on, rsp_lane_state}))
      else $error("stalled result changed");

   // every transaction yields a result in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted transaction gave no result");

   // an off request always ends in the off state
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_op == tllc_pkg::OP_REQUEST &&
      req_request == 2'(tllc_pkg::REQ_OFF)
      |=> rsp_lane_state == 3'(tllc_pkg::LANE_OFF))
      else $error("off request did not reach off");

   // off shows no light; in stop, go or out-of-order, yellow is never lit with red or green
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_lane_state == 3'(tllc_pkg::LANE_OFF)
      |-> !rsp_red_on && !rsp_yellow_on && !rsp_green_on)
      else $error("lights on while off");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_lane_state == 3'(tllc_pkg::LANE_STOP) ||
                    rsp_lane_state == 3'(tllc_pkg::LANE_GO) ||
                    rsp_lane_state == 3'(tllc_pkg::LANE_OOO))
      |-> !rsp_yellow_on || !(rsp_red_on || rsp_green_on))
      else $error("yellow lit with another light in a steady state");

endmodule

bind three_light_lane_controller_core tllc_checker u_tllc_checker (.*);

FILE: test/three_light_lane_controller_core_tb.sv
`timescale 1ns / 100ps
// testbench for the three-light lane controller core: directed table, then random traffic
module three_light_lane_controller_core_tb;

   localparam int unsigned TIMER_BITS       = 16;
   localparam logic [1:0]  CSR_SPARE_INDEX  = 2'd3;
   localparam int unsigned ITEM_GOAL        = 1750;
   localparam int unsigned PHASE_COUNT      = 14;
   localparam int unsigned CALM_PHASES      = 2;
   localparam int unsigned PRESSURE_PHASE   = 2;
   localparam int unsigned LONG_HOLD_CYCLES = 200;
   localparam int unsigned SETTLE_CYCLES    = 4;
   localparam int unsigned CYCLE_LIMIT      = 600000;

   typedef struct packed {
      logic                    red;
      logic                    yellow;
      logic                    green;
      tllc_pkg::lane_mode_type state;
   } lane_view_type;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type          kind;
      logic                  op;
      tllc_pkg::request_type rq;
      logic                  typed;
      lane_view_type         view;
      logic [1:0]            csr_idx;
      logic [15:0]           csr_data;
   } script_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_op;
   logic [1:0]  req_request;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_red_on;
   logic        rsp_yellow_on;
   logic        rsp_green_on;
   logic [2:0]  rsp_lane_state;
   logic        csr_write_en;
   logic [1:0]  csr_index;
   logic [15:0] csr_write_data;

   // lane predictor state and its copy of the registers
   tllc_pkg::lane_mode_type lane_mode_q;
   logic [TIMER_BITS-1:0]   transition_left;
   logic [TIMER_BITS-1:0]   blink_left;
   logic [2:0]              lamp_bits;
   logic [15:0]             transition_ticks_q;
   logic [15:0]             blink_ticks_q;
   logic [2:0]              fitted_q;

   lane_view_type lane_views_due[$];
   int unsigned   fail_count = 0;
   int unsigned   cycle_count = 0;
   int unsigned   gap_pct = 0;
   int unsigned   stall_pct = 0;
   bit            hold_off_request = 1'b0;
   bit            hold_off_done = 1'b0;

   three_light_lane_controller_core #(
      .TIMER_WIDTH(TIMER_BITS)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_request    (req_request),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_red_on     (rsp_red_on),
      .rsp_yellow_on  (rsp_yellow_on),
      .rsp_green_on   (rsp_green_on),
      .rsp_lane_state (rsp_lane_state),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // period cut to the timer width, zero runs as one tick
   function automatic logic [TIMER_BITS-1:0] timer_reload(logic [15:0] period);
      logic [TIMER_BITS-1:0] cut;
      cut = TIMER_BITS'(period);
      return (cut == '0) ? TIMER_BITS'(1) : cut;
   endfunction

   // apply one transaction to the predicted lane and return the visible result
   function automatic lane_view_type advance_lane(logic op, tllc_pkg::request_type rq);
      lane_view_type view;
      logic [2:0]    shown;
      if (op == tllc_pkg::OP_REQUEST) begin
         if (rq != tllc_pkg::REQ_OOO) blink_left = '0;
         case (rq)
            tllc_pkg::REQ_OFF: begin
               lamp_bits       = tllc_pkg::LIGHT_NONE;
               transition_left = '0;
               lane_mode_q     = tllc_pkg::LANE_OFF;
            end
            tllc_pkg::REQ_STOP: begin
               lamp_bits       = tllc_pkg::LIGHT_YELLOW;
               transition_left = timer_reload(transition_ticks_q);
               lane_mode_q     = tllc_pkg::LANE_TO_STOP;
            end
            tllc_pkg::REQ_GO: begin
               lamp_bits       = tllc_pkg::LIGHT_RED | tllc_pkg::LIGHT_YELLOW;
               transition_left = timer_reload(transition_ticks_q);
               lane_mode_q     = tllc_pkg::LANE_TO_GO;
            end
            default: begin
               lamp_bits       = tllc_pkg::LIGHT_NONE;
               transition_left = '0;
               blink_left      = timer_reload(blink_ticks_q);
               lane_mode_q     = tllc_pkg::LANE_OOO;
            end
         endcase
      end else if ((lane_mode_q == tllc_pkg::LANE_TO_STOP ||
                    lane_mode_q == tllc_pkg::LANE_TO_GO) && transition_left != '0) begin
         transition_left = transition_left - TIMER_BITS'(1);
         if (transition_left == '0) begin
            if (lane_mode_q == tllc_pkg::LANE_TO_STOP) begin
               lamp_bits   = tllc_pkg::LIGHT_RED;
               lane_mode_q = tllc_pkg::LANE_STOP;
            end else begin
               lamp_bits   = tllc_pkg::LIGHT_GREEN;
               lane_mode_q = tllc_pkg::LANE_GO;
            end
         end
      end else if (lane_mode_q == tllc_pkg::LANE_OOO && blink_left != '0) begin
         blink_left = blink_left - TIMER_BITS'(1);
         if (blink_left == '0) begin
            lamp_bits  = lamp_bits ^ tllc_pkg::LIGHT_YELLOW;
            blink_left = timer_reload(blink_ticks_q);
         end
      end
      shown       = lamp_bits & fitted_q;
      view.red    = shown[0];
      view.yellow = shown[1];
      view.green  = shown[2];
      view.state  = lane_mode_q;
      return view;
   endfunction

   function automatic script_row_type item_row(logic op, tllc_pkg::request_type rq);
      script_row_type row;
      row.kind     = ROW_ITEM;
      row.op       = op;
      row.rq       = rq;
      row.typed    = 1'b0;
      row.view     = '0;
      row.csr_idx  = '0;
      row.csr_data = '0;
      return row;
   endfunction

   function automatic script_row_type typed_row(logic op, tllc_pkg::request_type rq,
                                                logic [2:0] lights,
                                                tllc_pkg::lane_mode_type st);
      script_row_type row;
      row       = item_row(op, rq);
      row.typed = 1'b1;
      row.view  = '{lights[0], lights[1], lights[2], st};
      return row;
   endfunction

   function automatic script_row_type csr_row(logic [1:0] idx, logic [15:0] data);
      script_row_type row;
      row          = item_row(tllc_pkg::OP_TICK, tllc_pkg::REQ_OFF);
      row.kind     = ROW_CSR;
      row.csr_idx  = idx;
      row.csr_data = data;
      return row;
   endfunction

   // mostly short periods so transitions and blinks complete, sometimes the extremes
   function automatic logic [15:0] pick_period();
      case ($urandom_range(0, 19))
         0:       return 16'd0;
         1:       return 16'hFFFF;
         2:       return 16'($urandom);
         default: return 16'($urandom_range(1, 12));
      endcase
   endfunction

   // offer one transaction, record its expected result, then maybe pause
   task automatic offer(input logic op, input tllc_pkg::request_type rq,
                        input logic typed = 1'b0, input lane_view_type typed_view = '0);
      lane_view_type predicted;
      req_op      <= op;
      req_request <= rq;
      req_valid   <= 1'b1;
      do @(posedge clock); while (!req_ready);
      predicted = advance_lane(op, rq);
      lane_views_due.push_back(typed ? typed_view : predicted);
      @(negedge clock);
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
   endtask

   // let every outstanding result drain before touching the registers
   task automatic settle_lane();
      req_valid <= 1'b0;
      while (lane_views_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input logic [1:0] idx, input logic [15:0] data);
      csr_index      <= idx;
      csr_write_data <= data;
      csr_write_en   <= 1'b1;
      case (idx)
         tllc_pkg::CSR_TRANSITION_TICKS: transition_ticks_q = data;
         tllc_pkg::CSR_BLINK_TICKS:      blink_ticks_q = data;
         tllc_pkg::CSR_LIGHTS_FITTED:    fitted_q = data[2:0];
         default: ;
      endcase
      @(negedge clock);
      csr_write_en <= 1'b0;
      @(negedge clock);
   endtask

   // result side ready: random stall bursts, plus one long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request && !hold_off_done) begin
            hold_off_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES - 1) @(negedge clock);
         end else if (stall_pct != 0 && $urandom_range(0, 399) < stall_pct) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(0, 14)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // compare each accepted result with the oldest expectation
   always @(posedge clock) begin : result_check
      lane_view_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (lane_views_due.size() == 0) begin
            $error("result transaction with nothing outstanding");
            fail_count++;
         end else begin
            due = lane_views_due.pop_front();
            if (rsp_red_on !== due.red) begin
               $error("red_on: expected %0d, actual %0d", due.red, rsp_red_on);
               fail_count++;
            end
            if (rsp_yellow_on !== due.yellow) begin
               $error("yellow_on: expected %0d, actual %0d", due.yellow, rsp_yellow_on);
               fail_count++;
            end
            if (rsp_green_on !== due.green) begin
               $error("green_on: expected %0d, actual %0d", due.green, rsp_green_on);
               fail_count++;
            end
            if (rsp_lane_state !== due.state) begin
               $error("lane_state: expected %0d, actual %0d", due.state, rsp_lane_state);
               fail_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      script_row_type        directed_rows[$];
      int unsigned           counted;
      int unsigned           run_len;
      logic                  op;
      tllc_pkg::request_type rq;

      reset          = 1'b1;
      req_valid      = 1'b0;
      req_op         = tllc_pkg::OP_TICK;
      req_request    = tllc_pkg::REQ_OFF;
      csr_write_en   = 1'b0;
      csr_index      = tllc_pkg::CSR_TRANSITION_TICKS;
      csr_write_data = '0;

      lane_mode_q        = tllc_pkg::LANE_OFF;
      transition_left    = '0;
      blink_left         = '0;
      lamp_bits          = tllc_pkg::LIGHT_NONE;
      transition_ticks_q = tllc_pkg::RESET_TRANSITION_TICKS;
      blink_ticks_q      = tllc_pkg::RESET_BLINK_TICKS;
      fitted_q           = tllc_pkg::LIGHT_ALL;

      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // defaults after reset, idle ticks, cancel of a transition
      directed_rows.push_back(typed_row(tllc_pkg::OP_TICK, tllc_pkg::REQ_OFF,
                                        tllc_pkg::LIGHT_NONE, tllc_pkg::LANE_OFF));
      directed_rows.push_back(typed_row(tllc_pkg::OP_REQUEST, tllc_pkg::REQ_OFF,
                                        tllc_pkg::LIGHT_NONE, tllc_pkg::LANE_OFF));
      directed_rows.push_back(typed_row(tllc_pkg::OP_REQUEST, tllc_pkg::REQ_STOP,
                                        tllc_pkg::LIGHT_YELLOW, tllc_pkg::LANE_TO_STOP));
      directed_rows.push_back(item_row(tllc_pkg::OP_TICK, tllc_pkg::REQ_GO));
      directed_rows.push_back(typed_row(tllc_pkg::OP_REQUEST, tllc_pkg::REQ_GO,
                                        tllc_pkg::LIGHT_RED | tllc_pkg::LIGHT_YELLOW,
                                        tllc_pkg::LANE_TO_GO));
      directed_rows.push_back(typed_row(tllc_pkg::OP_REQUEST, tllc_pkg::REQ_OOO,
                                        tllc_pkg::LIGHT_NONE, tllc_pkg::LANE_OOO));
      directed_rows.push_back(item_row(tllc_pkg::OP_TICK, tllc_pkg::REQ_OOO));
      directed_rows.push_back(typed_row(tllc_pkg::OP_REQUEST, tllc_pkg::REQ_OFF,
                                        tllc_pkg::LIGHT_NONE, tllc_pkg::LANE_OFF));
      // zero transition period runs as a single tick
      directed_rows.push_back(csr_row(tllc_pkg::CSR_TRANSITION_TICKS, 16'd0));
      directed_rows.push_back(csr_row(tllc_pkg::CSR_BLINK_TICKS, 16'd1));
      directed_rows.push_back(typed_row(tllc_pkg::OP_REQUEST, tllc_pkg::REQ_STOP,
                                        tllc_pkg::LIGHT_YELLOW, tllc_pkg::LANE_TO_STOP));
      directed_rows.push_back(item_row(tllc_pkg::OP_TICK, tllc_pkg::REQ_OFF));
      directed_rows.push_back(item_row(tllc_pkg::OP_TICK, tllc_pkg::REQ_STOP));
      directed_rows.push_back(typed_row(tllc_pkg::OP_REQUEST, tllc_pkg::REQ_GO,
                                        tllc_pkg::LIGHT_RED | tllc_pkg::LIGHT_YELLOW,
                                        tllc_pkg::LANE_TO_GO));
      directed_rows.push_back(item_row(tllc_pkg::OP_TICK, tllc_pkg::REQ_OFF));
      directed_rows.push_back(item_row(tllc_pkg::OP_REQUEST, tllc_pkg::REQ_GO));
      directed_rows.push_back(typed_row(tllc_pkg::OP_REQUEST, tllc_pkg::REQ_OOO,
                                        tllc_pkg::LIGHT_NONE, tllc_pkg::LANE_OOO));
      directed_rows.push_back(item_row(tllc_pkg::OP_TICK, tllc_pkg::REQ_OFF));
      directed_rows.push_back(item_row(tllc_pkg::OP_TICK, tllc_pkg::REQ_OFF));
      directed_rows.push_back(item_row(tllc_pkg::OP_REQUEST, tllc_pkg::REQ_OOO));
      // yellow not fitted, zero blink period
      directed_rows.push_back(csr_row(tllc_pkg::CSR_BLINK_TICKS, 16'd0));
      directed_rows.push_back(csr_row(tllc_pkg::CSR_TRANSITION_TICKS, 16'd3));
      directed_rows.push_back(csr_row(tllc_pkg::CSR_LIGHTS_FITTED, 16'd5));
      directed_rows.push_back(item_row(tllc_pkg::OP_REQUEST, tllc_pkg::REQ_OOO));
      directed_rows.push_back(item_row(tllc_pkg::OP_TICK, tllc_pkg::REQ_OFF));
      directed_rows.push_back(item_row(tllc_pkg::OP_REQUEST, tllc_pkg::REQ_STOP));
      directed_rows.push_back(item_row(tllc_pkg::OP_TICK, tllc_pkg::REQ_OFF));
      directed_rows.push_back(item_row(tllc_pkg::OP_REQUEST, tllc_pkg::REQ_OFF));
      // unknown register index, longest periods, nothing fitted
      directed_rows.push_back(csr_row(CSR_SPARE_INDEX, 16'hFFFF));
      directed_rows.push_back(csr_row(tllc_pkg::CSR_TRANSITION_TICKS, 16'hFFFF));
      directed_rows.push_back(csr_row(tllc_pkg::CSR_BLINK_TICKS, 16'hFFFF));
      directed_rows.push_back(csr_row(tllc_pkg::CSR_LIGHTS_FITTED, 16'd0));
      directed_rows.push_back(typed_row(tllc_pkg::OP_REQUEST, tllc_pkg::REQ_GO,
                                        tllc_pkg::LIGHT_NONE, tllc_pkg::LANE_TO_GO));
      directed_rows.push_back(item_row(tllc_pkg::OP_TICK, tllc_pkg::REQ_OFF));

      gap_pct   = 20;
      stall_pct = 20;
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            settle_lane();
            write_register(directed_rows[i].csr_idx, directed_rows[i].csr_data);
         end else begin
            offer(directed_rows[i].op, directed_rows[i].rq, directed_rows[i].typed,
                  directed_rows[i].view);
         end
      end

      // random phases, each with fresh register settings
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         settle_lane();
         write_register(tllc_pkg::CSR_TRANSITION_TICKS, pick_period());
         write_register(tllc_pkg::CSR_BLINK_TICKS, pick_period());
         write_register(tllc_pkg::CSR_LIGHTS_FITTED, 16'($urandom));
         if ($urandom_range(0, 3) == 0) write_register(CSR_SPARE_INDEX, 16'($urandom));

         if (phase >= PHASE_COUNT - CALM_PHASES) begin
            gap_pct   = 0;
            stall_pct = 0;
         end else if (phase == PRESSURE_PHASE) begin
            gap_pct          = 0;
            stall_pct        = 0;
            hold_off_request = 1'b1;
         end else begin
            gap_pct   = $urandom_range(0, 3) * 10;
            stall_pct = $urandom_range(0, 3) * 10;
         end

         counted = 0;
         while (counted < ITEM_GOAL / PHASE_COUNT) begin
            if ($urandom_range(0, 9) < 8) begin
               // a request followed by a run of ticks
               case ($urandom_range(0, 9))
                  0:       rq = tllc_pkg::REQ_OFF;
                  1, 2:    rq = tllc_pkg::REQ_OOO;
                  3, 4, 5: rq = tllc_pkg::REQ_STOP;
                  default: rq = tllc_pkg::REQ_GO;
               endcase
               offer(tllc_pkg::OP_REQUEST, rq);
               counted++;
               run_len = $urandom_range(0, 30);
               repeat (run_len) begin
                  counted++;
                  offer(tllc_pkg::OP_TICK, tllc_pkg::request_type'($urandom_range(0, 3)));
               end
            end else begin
               // noise
               op = 1'($urandom_range(0, 1));
               rq = tllc_pkg::request_type'($urandom_range(0, 3));
               counted++;
               offer(op, rq);
            end
         end
      end

      settle_lane();
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
